@@ design/base64_line_wrapped_encoder_defines.svh @@
// assertion macros for the base64 line wrapped encoder checker
// expects signals named clk and arst_n in the scope of use
`ifndef BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH
`define BASE64_LINE_WRAPPED_ENCODER_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define B64LE_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define B64LE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/b64le_pkg.sv @@
// shared types, constants and the alphabet function of the base64 encoder
// no dependencies
package b64le_pkg;

	localparam logic [7:0] LINE_WIDTH_RESET    = 8'd76;
	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [6:0] CHAR_PAD = 7'd61;
	localparam logic [6:0] CHAR_NL  = 7'd10;

	// slot index of the newline in a job, after the four symbol slots
	localparam logic [2:0] SLOT_NL = 3'd4;

	// one unit of work for the back end: a group of four characters and/or a newline
	typedef struct packed {
		logic            grp;
		logic            pad2;
		logic            pad3;
		logic            nl;
		logic [3:0][5:0] sym;
	} job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_status_t;

	function automatic logic [6:0] b64_char(input logic [5:0] v);
		logic [6:0] c;
		priority if (v < 6'd26) begin
			c = 7'd65 + 7'(v);
		end else if (v < 6'd52) begin
			c = 7'd71 + 7'(v);
		end else if (v < 6'd62) begin
			c = 7'(v) - 7'd4;
		end else if (v == 6'd62) begin
			c = 7'd43;
		end else begin
			c = 7'd47;
		end
		return c;
	endfunction

endpackage

@@ design/b64le_front.sv @@
// front end: accepts bytes and finish items, keeps pending bytes and column
// depends on b64le_pkg
module b64le_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [7:0]            cfg_wdata,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  in_kind,
	input  logic [7:0]            in_byte,
	output logic                  push,
	output b64le_pkg::job_t       push_job,
	input  b64le_pkg::q_status_t  q_stat
);
	import b64le_pkg::*;

	logic [7:0] line_width_q;
	logic [7:0] pend0_q;
	logic [7:0] pend1_q;
	logic [1:0] pcnt_q;
	logic [7:0] column_q;

	logic       acc;
	logic [8:0] next_col;
	logic       wrap;
	logic [7:0] b0;
	logic [7:0] b1;
	logic [7:0] b2;

	assign in_ready = !q_stat.full;
	assign acc      = in_valid && in_ready;

	// nine bit compare so a column of 252 or more still wraps
	assign next_col = {1'b0, column_q} + 9'd4;
	assign wrap     = next_col >= {1'b0, line_width_q};

	assign b0 = pend0_q;
	assign b1 = (pcnt_q == 2'd2) ? pend1_q : 8'd0;
	assign b2 = in_kind ? 8'd0 : in_byte;

	always_comb begin
		push_job.sym[0] = b0[7:2];
		push_job.sym[1] = {b0[1:0], b1[7:4]};
		push_job.sym[2] = {b1[3:0], b2[7:6]};
		push_job.sym[3] = b2[5:0];
		if (in_kind) begin
			push_job.grp  = pcnt_q != 2'd0;
			push_job.pad2 = pcnt_q == 2'd1;
			push_job.pad3 = 1'b1;
			push_job.nl   = (pcnt_q != 2'd0) || (column_q != 8'd0);
		end else begin
			push_job.grp  = pcnt_q == 2'd2;
			push_job.pad2 = 1'b0;
			push_job.pad3 = 1'b0;
			push_job.nl   = (pcnt_q == 2'd2) && wrap;
		end
	end

	// finish with nothing to flush queues no job
	assign push = acc && (push_job.grp || push_job.nl);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			line_width_q <= LINE_WIDTH_RESET;
		end else if (cfg_we) begin
			line_width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend0_q  <= 8'd0;
			pend1_q  <= 8'd0;
			pcnt_q   <= 2'd0;
			column_q <= 8'd0;
		end else if (acc) begin
			if (in_kind) begin
				pend0_q  <= 8'd0;
				pend1_q  <= 8'd0;
				pcnt_q   <= 2'd0;
				column_q <= 8'd0;
			end else if (pcnt_q == 2'd2) begin
				pcnt_q   <= 2'd0;
				column_q <= wrap ? 8'd0 : next_col[7:0];
			end else begin
				if (pcnt_q == 2'd0) begin
					pend0_q <= in_byte;
				end else begin
					pend1_q <= in_byte;
				end
				pcnt_q <= pcnt_q + 2'd1;
			end
		end
	end

endmodule

@@ design/b64le_queue.sv @@
// job queue between front and back end, register based
// depends on b64le_pkg
module b64le_queue #(
	parameter int unsigned DEPTH = b64le_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  b64le_pkg::job_t       push_job,
	input  logic                  pop,
	output b64le_pkg::job_t       head,
	output b64le_pkg::q_status_t  q_stat
);
	import b64le_pkg::*;

	localparam int unsigned IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);

	job_t          mem_q [DEPTH];
	logic [IW-1:0] wr_ptr_q;
	logic [IW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign q_stat.full  = cnt_q == CW'(DEPTH);
	assign q_stat.empty = cnt_q == '0;
	assign head         = mem_q[rd_ptr_q];

	function automatic logic [IW-1:0] ptr_inc(input logic [IW-1:0] p);
		return (p == IW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= ptr_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

@@ design/b64le_back.sv @@
// back end: serializes one job into characters, one per cycle while out_ready does not stall, into the output register
// depends on b64le_pkg
module b64le_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  b64le_pkg::q_status_t  q_stat,
	input  b64le_pkg::job_t       head,
	output logic                  pop,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [6:0]            out_char,
	output logic                  out_last
);
	import b64le_pkg::*;

	logic       busy_q;
	job_t       job_q;
	logic [2:0] slot_q;
	logic       out_valid_q;
	logic [6:0] out_char_q;
	logic       out_last_q;

	logic       load;
	logic       adv;
	logic       cur_last;
	logic [6:0] cur_char;

	assign load = !out_valid_q || out_ready;
	assign adv  = busy_q && load;

	assign cur_last = (slot_q == SLOT_NL) || ((slot_q == 3'd3) && !job_q.nl);

	always_comb begin
		if (slot_q == SLOT_NL) begin
			cur_char = CHAR_NL;
		end else if ((slot_q == 3'd2 && job_q.pad2) || (slot_q == 3'd3 && job_q.pad3)) begin
			cur_char = CHAR_PAD;
		end else begin
			cur_char = b64_char(job_q.sym[slot_q[1:0]]);
		end
	end

	// take the next job as the current one finishes, so characters run back to back
	assign pop = !q_stat.empty && (!busy_q || (adv && cur_last));

	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (adv) begin
			out_char_q <= cur_char;
			out_last_q <= cur_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			slot_q      <= 3'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				slot_q <= head.grp ? 3'd0 : SLOT_NL;
			end else if (adv) begin
				if (cur_last) begin
					busy_q <= 1'b0;
				end else begin
					slot_q <= slot_q + 3'd1;
				end
			end
			if (load) begin
				out_valid_q <= adv;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_char  = out_char_q;
	assign out_last  = out_last_q;

endmodule

@@ design/base64_line_wrapped_encoder.sv @@
// base64 encoder with line wrap: one byte in per transaction, one character out per transaction
// with the back end idle, a character of an accepted item passes the job queue, the back end job
//   register and the output register before it is valid
// throughput: one character per cycle while m_axis_tready does not stall, set by the back end
//   serializer; input takes one item per cycle while the job queue has room
// reset: arst_n clears pending bytes, column, queue and output; line width returns to 76
module base64_line_wrapped_encoder #(
	parameter int unsigned QUEUE_DEPTH = b64le_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata,       // line_width
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,    // data_byte
	input  logic       s_axis_tuser,    // kind
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,    // character[6:0], zero fill
	output logic       m_axis_tlast     // last_of_run
);
	import b64le_pkg::*;

	logic      push;
	job_t      push_job;
	logic      pop;
	job_t      head;
	q_status_t q_stat;
	logic [6:0] out_char;

	b64le_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_kind   (s_axis_tuser),
		.in_byte   (s_axis_tdata),
		.push      (push),
		.push_job  (push_job),
		.q_stat    (q_stat)
	);

	b64le_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	b64le_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_stat    (q_stat),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (out_char),
		.out_last  (m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, out_char};

endmodule

@@ design/b64le_checker.sv @@
// port level checker for the base64 encoder, bound to the top level
// depends on base64_line_wrapped_encoder_defines.svh
`include "base64_line_wrapped_encoder_defines.svh"

module b64le_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_axis_tvalid,
	input logic       m_axis_tready,
	input logic [7:0] m_axis_tdata,
	input logic       m_axis_tlast
);

	`B64LE_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "stalled output transaction changed")
	`B64LE_ASSERT_SAME(a_nl_last, m_axis_tvalid && m_axis_tdata == 8'd10, m_axis_tlast, "newline not marked last")
	`B64LE_ASSERT_SAME(a_pad_not_last, m_axis_tvalid && m_axis_tdata == 8'd61, !m_axis_tlast, "padding ended a run")
	`B64LE_ASSERT_NEXT(a_pad_then, m_axis_tvalid && m_axis_tready && m_axis_tdata == 8'd61 && m_axis_tlast == 1'b0, !m_axis_tvalid || m_axis_tdata == 8'd61 || m_axis_tdata == 8'd10, "padding followed by symbol")

endmodule

bind base64_line_wrapped_encoder b64le_checker u_b64le_checker (.*);
